@@ rtl/core/sst_pkg.sv @@
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants of the sorted schedule table
// Sizes, operation and result codes, and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sst_pkg;

   localparam int CHANNELS    = 8;
   localparam int MAX_RECORDS = 16;

   // Fixed field widths of the request and response
   localparam int KIND_W   = 2;
   localparam int CH_W     = 3;
   localparam int KEY_W    = 11;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 4;
   localparam int RCNT_W   = 5;

   // Derived storage widths
   localparam int ENTRY_W = KEY_W + 1;
   localparam int IDX_W   = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int CNT_W   = $clog2(MAX_RECORDS + 1);
   localparam int DEPTH   = CHANNELS * MAX_RECORDS;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [1:0] {
      KIND_FIND   = 2'd0,
      KIND_ADD    = 2'd1,
      KIND_DELETE = 2'd2,
      KIND_NONE   = 2'd3
   } sst_kind_type;

   typedef enum logic [1:0] {
      RES_OK        = 2'd0,
      RES_NOT_FOUND = 2'd1,
      RES_FULL      = 2'd2
   } sst_status_type;

   typedef enum logic [1:0] {
      CNT_KEEP = 2'd0,
      CNT_INC  = 2'd1,
      CNT_DEC  = 2'd2
   } sst_cnt_op_type;

   typedef enum logic [2:0] {
      S_IDLE   = 3'd0,
      S_SCAN   = 3'd1,
      S_DECIDE = 3'd2,
      S_SHIFT  = 3'd3,
      S_PUT    = 3'd4,
      S_FINISH = 3'd5
   } sst_state_type;

   // Controller to datapath
   typedef struct packed {
      logic                 load;
      logic                 rd_en;
      logic                 scan;
      logic [IDX_W-1:0]     rd_idx;
      logic                 wr_en;
      logic                 wr_new;
      logic [IDX_W-1:0]     wr_idx;
      logic                 emit;
      sst_status_type       status;
      logic                 fstate;
      logic [IDX_W-1:0]     pos;
      sst_cnt_op_type       cnt_op;
   } sst_cmd_type;

   // Datapath to controller
   typedef struct packed {
      sst_kind_type         kind;
      logic                 bad_ch;
      logic [CNT_W-1:0]     n;
      logic                 hit;
      logic [IDX_W-1:0]     hit_idx;
      logic                 gt;
      logic [IDX_W-1:0]     gt_idx;
      logic                 out_busy;
   } sst_sts_type;

endpackage

@@ rtl/core/sst_datapath.sv @@
// ----------------------------------------------------------------------------
// sst_datapath: record memory, channel counts and response register
// Holds the captured request, walks the record memory on command,
// tracks the match and insertion point, and forms the response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sst_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          req_tuser,
   input  logic [15:0]         req_tdata,
   input  sst_pkg::sst_cmd_type cmd,
   output sst_pkg::sst_sts_type sts,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata
);

   // Captured request
   sst_pkg::sst_kind_type          kind_ff;
   logic [sst_pkg::CH_W-1:0]       ch_ff;
   logic [sst_pkg::KEY_W-1:0]      key_ff;
   logic                           st_ff;
   logic                           bad_ff;
   logic [sst_pkg::CNT_W-1:0]      n_ff;

   // Record memory and its registered read port
   logic [sst_pkg::ENTRY_W-1:0]    mem [sst_pkg::DEPTH];
   logic [sst_pkg::ENTRY_W-1:0]    rd_data_ff;
   logic [sst_pkg::ADDR_W-1:0]     rd_addr;
   logic [sst_pkg::ADDR_W-1:0]     wr_addr;
   logic [sst_pkg::ENTRY_W-1:0]    wr_data;

   // Scan tracking
   logic                           cmp_vld_ff;
   logic [sst_pkg::IDX_W-1:0]      cmp_idx_ff;
   logic                           hit_ff;
   logic [sst_pkg::IDX_W-1:0]      hit_idx_ff;
   logic                           hit_st_ff;
   logic                           gt_ff;
   logic [sst_pkg::IDX_W-1:0]      gt_idx_ff;

   // Per-channel counts
   logic [sst_pkg::CNT_W-1:0]      cnt_ff [sst_pkg::CHANNELS];
   logic [sst_pkg::CNT_W-1:0]      cnt_new;

   // Response register
   logic                           rsp_valid_ff;
   sst_pkg::sst_status_type        rsp_status_ff;
   logic                           rsp_fstate_ff;
   logic [sst_pkg::POS_W-1:0]      rsp_pos_ff;
   logic [sst_pkg::RCNT_W-1:0]     rsp_cnt_ff;

   logic [sst_pkg::CH_W-1:0]       req_ch;
   logic                           req_bad;
   logic [sst_pkg::KEY_W-1:0]      entry_key;

   assign req_ch    = req_tdata[sst_pkg::CH_W-1:0];
   assign req_bad   = (int'(req_ch) >= sst_pkg::CHANNELS);
   assign entry_key = rd_data_ff[sst_pkg::KEY_W-1:0];

   assign rd_addr = sst_pkg::ADDR_W'(int'(ch_ff) * sst_pkg::MAX_RECORDS + int'(cmd.rd_idx));
   assign wr_addr = sst_pkg::ADDR_W'(int'(ch_ff) * sst_pkg::MAX_RECORDS + int'(cmd.wr_idx));
   assign wr_data = cmd.wr_new ? {st_ff, key_ff} : rd_data_ff;

   always_comb begin
      case (cmd.cnt_op)
         sst_pkg::CNT_INC: cnt_new = n_ff + 1'b1;
         sst_pkg::CNT_DEC: cnt_new = n_ff - 1'b1;
         default:          cnt_new = n_ff;
      endcase
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= sst_pkg::sst_kind_type'(req_tuser[sst_pkg::KIND_W-1:0]);
         ch_ff   <= req_ch;
         key_ff  <= req_tdata[sst_pkg::CH_W +: sst_pkg::KEY_W];
         st_ff   <= req_tdata[sst_pkg::CH_W + sst_pkg::KEY_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bad_ff <= 1'b0;
         n_ff   <= '0;
      end else if (cmd.load) begin
         bad_ff <= req_bad;
         n_ff   <= req_bad ? '0 : cnt_ff[req_ch];
      end
   end

   // Record memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Compare each scanned entry in the cycle after it is read
   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff <= 1'b0;
         hit_ff     <= 1'b0;
         gt_ff      <= 1'b0;
      end else begin
         cmp_vld_ff <= cmd.rd_en & cmd.scan;
         if (cmd.load) begin
            hit_ff <= 1'b0;
            gt_ff  <= 1'b0;
         end else if (cmp_vld_ff) begin
            if (!hit_ff && entry_key == key_ff) begin
               hit_ff <= 1'b1;
            end
            if (!gt_ff && key_ff < entry_key) begin
               gt_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         cmp_idx_ff <= cmd.rd_idx;
      end
      if (cmp_vld_ff && !hit_ff && entry_key == key_ff) begin
         hit_idx_ff <= cmp_idx_ff;
         hit_st_ff  <= rd_data_ff[sst_pkg::KEY_W];
      end
      if (cmp_vld_ff && !gt_ff && key_ff < entry_key) begin
         gt_idx_ff <= cmp_idx_ff;
      end
   end

   // Channel counts
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < sst_pkg::CHANNELS; c++) begin
            cnt_ff[c] <= '0;
         end
      end else if (cmd.emit && cmd.cnt_op != sst_pkg::CNT_KEEP) begin
         cnt_ff[ch_ff] <= cnt_new;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff <= cmd.status;
         rsp_fstate_ff <= cmd.fstate & hit_st_ff;
         rsp_pos_ff    <= sst_pkg::POS_W'(cmd.pos);
         rsp_cnt_ff    <= sst_pkg::RCNT_W'(cnt_new);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_cnt_ff, rsp_pos_ff, rsp_fstate_ff, rsp_status_ff};

   assign sts.kind     = kind_ff;
   assign sts.bad_ch   = bad_ff;
   assign sts.n        = n_ff;
   assign sts.hit      = hit_ff;
   assign sts.hit_idx  = hit_idx_ff;
   assign sts.gt       = gt_ff;
   assign sts.gt_idx   = gt_idx_ff;
   assign sts.out_busy = rsp_valid_ff & ~rsp_tready;

endmodule

@@ rtl/core/sst_controller.sv @@
// ----------------------------------------------------------------------------
// sst_controller: operation sequencer of the sorted schedule table
// Accepts one request, walks the channel's records, then updates,
// shifts and inserts or closes the gap, and releases the response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sst_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  sst_pkg::sst_sts_type sts,
   output sst_pkg::sst_cmd_type cmd
);

   sst_pkg::sst_state_type         state_ff, state_in;
   logic [sst_pkg::CNT_W-1:0]      idx_ff, idx_in;
   logic [sst_pkg::CNT_W-1:0]      left_ff, left_in;
   logic                           up_ff, up_in;
   logic                           pend_ff, pend_in;
   logic [sst_pkg::IDX_W-1:0]      pend_dst_ff, pend_dst_in;
   logic [sst_pkg::IDX_W-1:0]      pos_ff, pos_in;
   sst_pkg::sst_status_type        status_ff, status_in;
   logic                           fstate_ff, fstate_in;
   sst_pkg::sst_cnt_op_type        cnt_op_ff, cnt_op_in;
   logic [sst_pkg::IDX_W-1:0]      at;

   assign at = sts.gt ? sts.gt_idx : sst_pkg::IDX_W'(sts.n);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sst_pkg::S_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      left_ff     <= left_in;
      up_ff       <= up_in;
      pend_dst_ff <= pend_dst_in;
      pos_ff      <= pos_in;
      status_ff   <= status_in;
      fstate_ff   <= fstate_in;
      cnt_op_ff   <= cnt_op_in;
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      left_in     = left_ff;
      up_in       = up_ff;
      pend_in     = pend_ff;
      pend_dst_in = pend_dst_ff;
      pos_in      = pos_ff;
      status_in   = status_ff;
      fstate_in   = fstate_ff;
      cnt_op_in   = cnt_op_ff;
      req_tready  = 1'b0;
      cmd         = '0;

      case (state_ff)
         sst_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               idx_in   = '0;
               state_in = sst_pkg::S_SCAN;
            end
         end

         sst_pkg::S_SCAN: begin
            if (idx_ff < sts.n) begin
               cmd.rd_en  = 1'b1;
               cmd.scan   = 1'b1;
               cmd.rd_idx = sst_pkg::IDX_W'(idx_ff);
               idx_in     = idx_ff + 1'b1;
            end else begin
               state_in = sst_pkg::S_DECIDE;
            end
         end

         sst_pkg::S_DECIDE: begin
            status_in = sst_pkg::RES_OK;
            fstate_in = 1'b0;
            pos_in    = '0;
            cnt_op_in = sst_pkg::CNT_KEEP;
            pend_in   = 1'b0;
            state_in  = sst_pkg::S_FINISH;
            if (sts.bad_ch) begin
               status_in = sst_pkg::RES_NOT_FOUND;
            end else begin
               case (sts.kind)
                  sst_pkg::KIND_FIND: begin
                     if (sts.hit) begin
                        pos_in    = sts.hit_idx;
                        fstate_in = 1'b1;
                     end else begin
                        status_in = sst_pkg::RES_NOT_FOUND;
                     end
                  end
                  sst_pkg::KIND_ADD: begin
                     if (sts.hit) begin
                        // existing key: rewrite its state bit in place
                        pos_in     = sts.hit_idx;
                        cmd.wr_en  = 1'b1;
                        cmd.wr_new = 1'b1;
                        cmd.wr_idx = sts.hit_idx;
                     end else if (sts.n >= sst_pkg::CNT_W'(sst_pkg::MAX_RECORDS)) begin
                        status_in = sst_pkg::RES_FULL;
                     end else begin
                        // move entries at..n-1 up by one, highest first
                        pos_in    = at;
                        cnt_op_in = sst_pkg::CNT_INC;
                        up_in     = 1'b1;
                        idx_in    = sts.n - 1'b1;
                        left_in   = sts.n - sst_pkg::CNT_W'(at);
                        state_in  = sst_pkg::S_SHIFT;
                     end
                  end
                  sst_pkg::KIND_DELETE: begin
                     if (sts.hit) begin
                        // move entries hit+1..n-1 down by one, lowest first
                        pos_in    = sts.hit_idx;
                        cnt_op_in = sst_pkg::CNT_DEC;
                        up_in     = 1'b0;
                        idx_in    = sst_pkg::CNT_W'(sts.hit_idx) + 1'b1;
                        left_in   = sts.n - 1'b1 - sst_pkg::CNT_W'(sts.hit_idx);
                        state_in  = sst_pkg::S_SHIFT;
                     end else begin
                        status_in = sst_pkg::RES_NOT_FOUND;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         sst_pkg::S_SHIFT: begin
            // write back the entry read last cycle while reading the next
            cmd.wr_en  = pend_ff;
            cmd.wr_idx = pend_dst_ff;
            if (left_ff != '0) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_idx  = sst_pkg::IDX_W'(idx_ff);
               pend_in     = 1'b1;
               pend_dst_in = up_ff ? sst_pkg::IDX_W'(idx_ff + 1'b1)
                                   : sst_pkg::IDX_W'(idx_ff - 1'b1);
               idx_in      = up_ff ? idx_ff - 1'b1 : idx_ff + 1'b1;
               left_in     = left_ff - 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = up_ff ? sst_pkg::S_PUT : sst_pkg::S_FINISH;
               end
            end
         end

         sst_pkg::S_PUT: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_new = 1'b1;
            cmd.wr_idx = pos_ff;
            state_in   = sst_pkg::S_FINISH;
         end

         sst_pkg::S_FINISH: begin
            if (!sts.out_busy) begin
               cmd.emit   = 1'b1;
               cmd.status = status_ff;
               cmd.fstate = fstate_ff;
               cmd.pos    = pos_ff;
               cmd.cnt_op = cnt_op_ff;
               state_in   = sst_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = sst_pkg::S_IDLE;
         end
      endcase
   end

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !sts.out_busy)
      else $error("response emitted over an unread response");

   a_rd_wr_apart: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_en && cmd.rd_en) |-> (cmd.wr_idx != cmd.rd_idx))
      else $error("read and write hit the same record");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.status == sst_pkg::RES_FULL)
         |-> (sts.n == sst_pkg::CNT_W'(sst_pkg::MAX_RECORDS)))
      else $error("full reported below capacity");

   a_inc_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.cnt_op == sst_pkg::CNT_INC)
         |-> (sts.n < sst_pkg::CNT_W'(sst_pkg::MAX_RECORDS)))
      else $error("insert into a full channel");

endmodule

@@ rtl/core/sorted_schedule_table.sv @@
// ----------------------------------------------------------------------------
// sorted_schedule_table: per-channel sorted schedule records
// Order: once a request is taken, the channel's n records are scanned, n being
// the channel's record count; an insert then moves the records from its place
// up and writes the new one, and a delete moves those above the match down.
// Throughput: one request at a time; the next is taken the cycle after the
// response is loaded, later if the previous response still waits.
// Reset clears all channel counts at once; record contents stay undefined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_schedule_table (
   input  logic        clock,
   input  logic        reset,

   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tuser,   // [1:0] kind, [7:2] zero
   input  logic [15:0] req_tdata,   // [2:0] channel, [13:3] minute_key,
                                    // [14] new_state, [15] zero

   // Response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [1:0] status, [2] found_state,
                                    // [6:3] position, [11:7] record_count,
                                    // [15:12] zero
);

   // Command and status bundles between sequencer and datapath
   sst_pkg::sst_cmd_type cmd;
   sst_pkg::sst_sts_type sts;

   // Sequencer: accept a request only when idle, walk the channel's
   // records one per cycle, then rewrite an entry or shift to insert or drop one, and
   // hold the response until the output register is free.
   sst_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Datapath: record memory of CHANNELS x MAX_RECORDS entries (state bit
   // above the key), per-channel counts in flops, scan compare and the
   // response register that lets a finished response wait for the sink.
   sst_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
